[design/rxsu_pkg.sv]
// ----------------------------------------------------------------------------
// Replica exchange swap unit package
// Field widths, operation codes and the fixed-point exponent table of the
// swap unit; its checker uses the field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rxsu_pkg;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 6;
    localparam int BETA_W   = 20;
    localparam int ENERGY_W = 24;
    localparam int RAND_W   = 16;
    localparam int CNT_W    = 32;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_BETA   = 2'd0;
    localparam t_op OP_ENERGY = 2'd1;
    localparam t_op OP_SWAP   = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    localparam logic [20:0] LOG2E_Q16 = 21'd94548;
    localparam logic [22:0] T_SAT     = 23'h400000;

    // 2^(-k/16) in Q1.16, rounded.
    function automatic logic [16:0] pow2_frac(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd62757;
            4'd2:  v = 17'd60097;
            4'd3:  v = 17'd57549;
            4'd4:  v = 17'd55109;
            4'd5:  v = 17'd52773;
            4'd6:  v = 17'd50535;
            4'd7:  v = 17'd48393;
            4'd8:  v = 17'd46341;
            4'd9:  v = 17'd44376;
            4'd10: v = 17'd42495;
            4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;
            4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;
            4'd15: v = 17'd34219;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[design/rxsu_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rxsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/replica_exchange_swap_unit.sv]
// ----------------------------------------------------------------------------
// Replica exchange swap unit
// Holds slot betas, node energies, the slot-to-node map and per-slot try and
// accept counters, and decides swaps with a fixed-point Metropolis test.
//
// Channel  Handshake                  Fields
// input    i_in_valid / o_in_stall    op, slot_a, slot_b, beta_value,
//                                     energy_value, rand_u
// output   o_out_valid / i_out_stall  accepted, node_a, node_b, tries, accepts
//
// A write skips the table reads, a counter read skips the exponent steps, and a swap
// uses the one multiplier a second time when the exponent is negative.
// Table reads are single-port and a swap writes back slot a, then slot b.
// Reset is synchronous; per-slot valid bits restore the map and counters at once.
// A finished result waits in the output register while the next transaction
// runs, and a second result holds the unit until the first one leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module replica_exchange_swap_unit #(
    parameter int SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rxsu_pkg::OP_W-1:0]      i_op,
    input  logic [rxsu_pkg::SLOT_W-1:0]    i_slot_a,
    input  logic [rxsu_pkg::SLOT_W-1:0]    i_slot_b,
    input  logic [rxsu_pkg::BETA_W-1:0]    i_beta_value,
    input  logic signed [rxsu_pkg::ENERGY_W-1:0] i_energy_value,
    input  logic [rxsu_pkg::RAND_W-1:0]    i_rand_u,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_accepted,
    output logic [rxsu_pkg::SLOT_W-1:0]    o_node_a,
    output logic [rxsu_pkg::SLOT_W-1:0]    o_node_b,
    output logic [rxsu_pkg::CNT_W-1:0]     o_tries,
    output logic [rxsu_pkg::CNT_W-1:0]     o_accepts
);

    import rxsu_pkg::*;

    localparam int AW = $clog2(SLOTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_RDEA = 4'd3;
    localparam logic [3:0] S_RDEB = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_MULX = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_MULY = 4'd8;
    localparam logic [3:0] S_DEC  = 4'd9;
    localparam logic [3:0] S_WRA  = 4'd10;
    localparam logic [3:0] S_WRB  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [SLOTS-1:0] r_map_vld;
    logic [SLOTS-1:0] r_cnt_vld;
    logic             r_out_valid;

    t_op                    r_op;
    logic [SLOT_W-1:0]      r_a;
    logic [SLOT_W-1:0]      r_b;
    logic [BETA_W-1:0]      r_bv;
    logic [ENERGY_W-1:0]    r_ev;
    logic [RAND_W-1:0]      r_u;
    logic                   r_bad;
    logic                   r_acc;
    logic [SLOT_W-1:0]      r_na;
    logic [SLOT_W-1:0]      r_nb;
    logic [BETA_W-1:0]      r_ba;
    logic [BETA_W-1:0]      r_bb;
    logic [CNT_W-1:0]       r_try_a;
    logic [CNT_W-1:0]       r_acc_a;
    logic [CNT_W-1:0]       r_try_b;
    logic [CNT_W-1:0]       r_acc_b;
    logic [ENERGY_W-1:0]    r_ea;
    logic signed [24:0]     r_de;
    logic signed [20:0]     r_db;
    logic signed [45:0]     r_prod;
    logic [22:0]            r_t;

    logic                   r_o_acc;
    logic [SLOT_W-1:0]      r_o_na;
    logic [SLOT_W-1:0]      r_o_nb;
    logic [CNT_W-1:0]       r_o_try;
    logic [CNT_W-1:0]       r_o_accs;

    logic                   in_accept;
    logic                   out_free;
    logic [AW-1:0]          a_idx;
    logic [AW-1:0]          b_idx;
    logic                   is_rw;

    logic                   beta_we;
    logic [BETA_W-1:0]      beta_rdata;
    logic                   energy_we;
    logic [AW-1:0]          energy_raddr;
    logic [ENERGY_W-1:0]    energy_rdata;
    logic                   map_we;
    logic [AW-1:0]          map_waddr;
    logic [SLOT_W-1:0]      map_wdata;
    logic [AW-1:0]          tab_raddr;
    logic [SLOT_W-1:0]      map_rdata;
    logic                   cnt_we;
    logic [AW-1:0]          cnt_waddr;
    logic [2*CNT_W-1:0]     cnt_wdata;
    logic [2*CNT_W-1:0]     cnt_rdata;

    logic signed [24:0]     mul_x;
    logic signed [20:0]     mul_y;
    logic signed [45:0]     mul_p;
    logic [45:0]            neg_prod;
    logic [16:0]            p_val;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_idx      = AW'(r_a);
    assign b_idx      = AW'(r_b);
    assign is_rw      = (r_op == OP_SWAP) || (r_op == OP_READ);

    assign beta_we      = (r_state == S_RDA) && (r_op == OP_BETA) && !r_bad;
    assign energy_we    = (r_state == S_RDA) && (r_op == OP_ENERGY) && !r_bad;
    assign energy_raddr = (r_state == S_RDEA) ? AW'(r_na) : AW'(r_nb);
    assign tab_raddr    = (r_state == S_RDA) ? a_idx : b_idx;

    assign map_we    = r_acc && ((r_state == S_WRA) || ((r_state == S_WRB) && (r_a != r_b)));
    assign map_waddr = (r_state == S_WRA) ? a_idx : b_idx;
    assign map_wdata = (r_state == S_WRA) ? r_nb : r_na;

    assign cnt_we    = (r_state == S_WRA) || ((r_state == S_WRB) && (r_a != r_b));
    assign cnt_waddr = (r_state == S_WRA) ? a_idx : b_idx;
    assign cnt_wdata = (r_state == S_WRA)
                     ? {r_try_a + CNT_W'(1), r_acc_a + CNT_W'(r_acc)}
                     : {r_try_b + CNT_W'(1), r_acc_b + CNT_W'(r_acc)};

    rxsu_ram #(.WIDTH(BETA_W), .DEPTH(SLOTS)) u_beta_ram (
        .i_clk   (i_clk),
        .i_we    (beta_we),
        .i_waddr (a_idx),
        .i_wdata (r_bv),
        .i_raddr (tab_raddr),
        .o_rdata (beta_rdata)
    );

    rxsu_ram #(.WIDTH(ENERGY_W), .DEPTH(SLOTS)) u_energy_ram (
        .i_clk   (i_clk),
        .i_we    (energy_we),
        .i_waddr (a_idx),
        .i_wdata (r_ev),
        .i_raddr (energy_raddr),
        .o_rdata (energy_rdata)
    );

    rxsu_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (map_rdata)
    );

    rxsu_ram #(.WIDTH(2*CNT_W), .DEPTH(SLOTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (cnt_rdata)
    );

    // The one multiplier forms the energy-beta product, then the exponent scale.
    always_comb begin
        if (r_state == S_MULX) begin
            mul_x = r_de;
            mul_y = r_db;
        end else begin
            mul_x = $signed({2'b00, r_t});
            mul_y = $signed(LOG2E_Q16);
        end
    end

    assign mul_p    = mul_x * mul_y;
    assign neg_prod = -r_prod;
    assign p_val    = pow2_frac(r_prod[31:28]) >> r_prod[35:32];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                n_state = (r_bad || !is_rw) ? S_DONE : S_RDB;
            end
            S_RDB:  n_state = S_RDEA;
            S_RDEA: n_state = (r_op == OP_READ) ? S_DONE : S_RDEB;
            S_RDEB: n_state = S_DIFF;
            S_DIFF: n_state = S_MULX;
            S_MULX: n_state = S_SAT;
            S_SAT:  n_state = r_prod[45] ? S_MULY : S_WRA;
            S_MULY: n_state = S_DEC;
            S_DEC:  n_state = S_WRA;
            S_WRA:  n_state = S_WRB;
            S_WRB:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_vld   <= '0;
            r_cnt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (map_we) begin
                r_map_vld[map_waddr] <= 1'b1;
            end
            if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_op;
            r_a   <= i_slot_a;
            r_b   <= i_slot_b;
            r_bv  <= i_beta_value;
            r_ev  <= i_energy_value;
            r_u   <= i_rand_u;
            r_acc <= 1'b0;
            r_bad <= (32'(i_slot_a) >= SLOTS) ||
                     (((i_op == OP_SWAP) || (i_op == OP_READ)) &&
                      (32'(i_slot_b) >= SLOTS));
        end
        if (r_state == S_RDB) begin
            r_na    <= r_map_vld[a_idx] ? map_rdata : r_a;
            r_ba    <= beta_rdata;
            r_try_a <= r_cnt_vld[a_idx] ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
            r_acc_a <= r_cnt_vld[a_idx] ? cnt_rdata[CNT_W-1:0] : '0;
        end
        if (r_state == S_RDEA) begin
            r_nb    <= r_map_vld[b_idx] ? map_rdata : r_b;
            r_bb    <= beta_rdata;
            r_try_b <= r_cnt_vld[b_idx] ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
            r_acc_b <= r_cnt_vld[b_idx] ? cnt_rdata[CNT_W-1:0] : '0;
        end
        if (r_state == S_RDEB) begin
            r_ea <= energy_rdata;
        end
        if (r_state == S_DIFF) begin
            r_de <= $signed({r_ea[ENERGY_W-1], r_ea}) -
                    $signed({energy_rdata[ENERGY_W-1], energy_rdata});
            r_db <= $signed({1'b0, r_ba}) - $signed({1'b0, r_bb});
        end
        if ((r_state == S_MULX) || (r_state == S_MULY)) begin
            r_prod <= mul_p;
        end
        if (r_state == S_SAT) begin
            if (!r_prod[45]) begin
                r_acc <= 1'b1;
            end
            r_t <= (neg_prod > 46'(T_SAT)) ? T_SAT : neg_prod[22:0];
        end
        if (r_state == S_DEC) begin
            r_acc <= (r_prod[45:36] == '0) && ({1'b0, r_u} < p_val);
        end
        if ((r_state == S_DONE) && out_free) begin
            if (r_bad || !is_rw) begin
                r_o_acc  <= 1'b0;
                r_o_na   <= '0;
                r_o_nb   <= '0;
                r_o_try  <= '0;
                r_o_accs <= '0;
            end else begin
                r_o_acc  <= r_acc;
                r_o_na   <= r_acc ? r_nb : r_na;
                r_o_nb   <= r_acc ? r_na : r_nb;
                r_o_try  <= (r_op == OP_SWAP) ? r_try_a + CNT_W'(1) : r_try_a;
                r_o_accs <= r_acc_a + CNT_W'(r_acc);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_o_acc;
    assign o_node_a    = r_o_na;
    assign o_node_b    = r_o_nb;
    assign o_tries     = r_o_try;
    assign o_accepts   = r_o_accs;

endmodule

[design/rxsu_checker.sv]
// ----------------------------------------------------------------------------
// Replica exchange swap unit checker
// Port-level checks on transaction ordering and output holding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rxsu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_accepted,
    input logic [rxsu_pkg::SLOT_W-1:0]    o_node_a,
    input logic [rxsu_pkg::SLOT_W-1:0]    o_node_b,
    input logic [rxsu_pkg::CNT_W-1:0]     o_tries,
    input logic [rxsu_pkg::CNT_W-1:0]     o_accepts
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_pend = r_pend;
        if (in_acc && !out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (!in_acc && out_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pend != 2'd0))
        else $error("result delivered without a pending transaction");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two transactions outstanding");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while the unit was idle");

    a_output_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid &&
        $stable({o_accepted, o_node_a, o_node_b, o_tries, o_accepts})))
        else $error("stalled result changed");

endmodule

bind replica_exchange_swap_unit rxsu_checker u_rxsu_checker (.*);
